### rtl/core/dsbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw-sync breakpoint queue package
// Shared sizes, register indexes, action codes, sequencer states and the
// structs that pass between the queue sequencer, the ring and the range scan.
// ----------------------------------------------------------------------------
package dsbq_pkg;

    // Ring geometry: DEPTH usable entries and one spare slot; a count tells full from empty.
    localparam int DEPTH  = 15;
    localparam int SLOTS  = DEPTH + 1;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Token ranges checked by the shared comparator.
    localparam int RANGES = 4;
    localparam int RIDX_W = (RANGES > 1) ? $clog2(RANGES) : 1;

    // Field widths.
    localparam int ADDR_W     = 32;
    localparam int TOKEN_W    = 16;
    localparam int RANGE_W    = 33;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;
    localparam int ACT_W      = 2;
    localparam int HIT_W      = 2;
    localparam int QC_W       = 4;

    // Range register packing.
    localparam int RANGE_FIRST_LSB = 0;
    localparam int RANGE_LAST_LSB  = 16;
    localparam int RANGE_EN_BIT    = 32;

    // Address bands of a push.
    localparam logic [ADDR_W-1:0] HIGH_ADDR     = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] SHUTDOWN_BASE = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_D = 3'd4;

    // Mode flag bits.
    localparam int MODE_HOLD_BIT = 1;

    // Opcodes.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_TOKEN = 1'b1;

    // Breakpoint actions.
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RETIRE,
        ST_READ,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             match;
        logic             hit;
        logic [HIT_W-1:0] idx;
    } scan_res_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] n;
        begin
            if (i == IDX_W'(SLOTS - 1))
            begin
                n = '0;
            end
            else
            begin
                n = i + 1'b1;
            end
            return n;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/dsbq_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw-sync breakpoint queue ring
// Address store with head and tail pointers and an entry count. A pop also
// reads the entry after the new head, which shows up in the cycle after the pop.
// ----------------------------------------------------------------------------
module dsbq_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dsbq_pkg::ring_cmd_t         cmd,
    input  logic [dsbq_pkg::ADDR_W-1:0] wdata,
    output logic [dsbq_pkg::CNT_W-1:0]  count,
    output logic [dsbq_pkg::ADDR_W-1:0] rd_data
);

    logic [dsbq_pkg::ADDR_W-1:0] mem [dsbq_pkg::SLOTS];
    logic [dsbq_pkg::ADDR_W-1:0] rd_data_reg;

    logic [dsbq_pkg::IDX_W-1:0] head_reg;
    logic [dsbq_pkg::IDX_W-1:0] head_next;
    logic [dsbq_pkg::IDX_W-1:0] tail_reg;
    logic [dsbq_pkg::IDX_W-1:0] tail_next;
    logic [dsbq_pkg::CNT_W-1:0] count_reg;
    logic [dsbq_pkg::CNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= wdata;
        end
        // The entry after the new head is the next breakpoint address.
        if (cmd.pop)
        begin
            rd_data_reg <= mem[dsbq_pkg::wrap_inc(dsbq_pkg::wrap_inc(head_reg))];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next  = dsbq_pkg::wrap_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = dsbq_pkg::wrap_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg < dsbq_pkg::CNT_W'(dsbq_pkg::DEPTH))
        else $error("push into a full ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop from an empty ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == dsbq_pkg::CNT_W'($past(count_reg) - 1'b1))
        else $error("ring count did not drop after a pop");

endmodule
`default_nettype wire

### rtl/core/dsbq_range_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw-sync breakpoint queue range scan
// Holds the token range registers and walks them one per cycle through a
// single range comparator, stopping at the first enabled range that holds
// the token. Token zero matches at once without a range.
// ----------------------------------------------------------------------------
module dsbq_range_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dsbq_pkg::CFG_IDX_W-1:0]  wr_sel,
    input  logic [dsbq_pkg::RANGE_W-1:0]    wr_data,
    input  logic                            scan_start,
    input  logic [dsbq_pkg::TOKEN_W-1:0]    token,
    output dsbq_pkg::scan_res_t             res
);

    logic [dsbq_pkg::RANGE_W-1:0] range_reg  [dsbq_pkg::RANGES];
    logic [dsbq_pkg::RANGE_W-1:0] range_next [dsbq_pkg::RANGES];

    logic                          running_reg;
    logic                          running_next;
    logic [dsbq_pkg::RIDX_W-1:0]   idx_reg;
    logic [dsbq_pkg::RIDX_W-1:0]   idx_next;
    dsbq_pkg::scan_res_t           res_reg;
    dsbq_pkg::scan_res_t           res_next;

    logic [dsbq_pkg::RANGE_W-1:0]  cur;
    logic [dsbq_pkg::TOKEN_W-1:0]  cur_first;
    logic [dsbq_pkg::TOKEN_W-1:0]  cur_last;
    logic                          cur_hit;

    // Each of the four ranges is written only when wr_sel selects it.
    always_comb
    begin
        for (int r = 0; r < dsbq_pkg::RANGES; r++)
        begin
            range_next[r] = range_reg[r];
            if (wr_en && wr_sel == dsbq_pkg::CFG_IDX_W'(r))
            begin
                range_next[r] = wr_data;
            end
        end
    end

    assign cur       = range_reg[idx_reg];
    assign cur_first = cur[dsbq_pkg::RANGE_FIRST_LSB +: dsbq_pkg::TOKEN_W];
    assign cur_last  = cur[dsbq_pkg::RANGE_LAST_LSB +: dsbq_pkg::TOKEN_W];
    assign cur_hit   = cur[dsbq_pkg::RANGE_EN_BIT] && (token >= cur_first)
                       && (token <= cur_last);

    always_comb
    begin
        running_next = running_reg;
        idx_next     = idx_reg;
        res_next     = '0;
        if (scan_start)
        begin
            idx_next = '0;
            if (token == '0)
            begin
                res_next.valid = 1'b1;
                res_next.match = 1'b1;
            end
            else
            begin
                running_next = 1'b1;
            end
        end
        else if (running_reg)
        begin
            if (cur_hit)
            begin
                running_next   = 1'b0;
                res_next.valid = 1'b1;
                res_next.match = 1'b1;
                res_next.hit   = 1'b1;
                res_next.idx   = dsbq_pkg::HIT_W'(idx_reg);
            end
            else if (idx_reg == dsbq_pkg::RIDX_W'(dsbq_pkg::RANGES - 1))
            begin
                running_next   = 1'b0;
                res_next.valid = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < dsbq_pkg::RANGES; r++)
            begin
                range_reg[r] <= '0;
            end
            running_reg <= 1'b0;
            idx_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            for (int r = 0; r < dsbq_pkg::RANGES; r++)
            begin
                range_reg[r] <= range_next[r];
            end
            running_reg <= running_next;
            idx_reg     <= idx_next;
            res_reg     <= res_next;
        end
    end

    assign res = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.hit |-> res_reg.valid && res_reg.match)
        else $error("range hit reported without a valid match");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> !running_reg)
        else $error("scan still running after its result");

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_start |-> !running_reg)
        else $error("scan started while a scan is running");

endmodule
`default_nettype wire

### rtl/core/draw_sync_breakpoint_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw-sync breakpoint queue
// Keeps a ring of command FIFO write addresses that mark pending breakpoints,
// enqueues them on high pushes and retires the head on matching draw-sync
// tokens and on pushes below the shutdown base.
//   Channel   Handshake              Payload
//   input     start, busy            opcode, fifo_address, token
//   result    done (one-cycle)       bp_action, bp_address, range_hit,
//                                    hit_index, queue_count, push_dropped
//   config    write_enable           reg_index, write_data
//
// A push passes through the decode and report states; a retirement adds the
// retire state and, when two or more entries remain, the read state, and a
// token adds the scan state. The range scan sets the long case: one range a
// cycle goes through the single comparator.
// Reset clears the pointers, the mode flags and the ranges; the ring store
// itself is not cleared. done is high for exactly one cycle per item and a
// new item may be transferred in that same cycle.
// ----------------------------------------------------------------------------
module draw_sync_breakpoint_queue_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [dsbq_pkg::ADDR_W-1:0]       fifo_address,
    input  logic [dsbq_pkg::TOKEN_W-1:0]      token,
    input  logic                              write_enable,
    input  logic [dsbq_pkg::CFG_IDX_W-1:0]    reg_index,
    input  logic [dsbq_pkg::CFG_DATA_W-1:0]   write_data,
    output logic                              done,
    output logic [dsbq_pkg::ACT_W-1:0]        bp_action,
    output logic [dsbq_pkg::ADDR_W-1:0]       bp_address,
    output logic                              range_hit,
    output logic [dsbq_pkg::HIT_W-1:0]        hit_index,
    output logic [dsbq_pkg::QC_W-1:0]         queue_count,
    output logic                              push_dropped
);

    dsbq_pkg::state_t state_reg;
    dsbq_pkg::state_t state_next;

    logic [dsbq_pkg::MODE_W-1:0]  mode_reg;
    logic [dsbq_pkg::MODE_W-1:0]  mode_next;
    logic                         opcode_reg;
    logic                         opcode_next;
    logic [dsbq_pkg::ADDR_W-1:0]  in_addr_reg;
    logic [dsbq_pkg::ADDR_W-1:0]  in_addr_next;
    logic [dsbq_pkg::TOKEN_W-1:0] token_reg;
    logic [dsbq_pkg::TOKEN_W-1:0] token_next;

    logic                         done_reg;
    logic                         done_next;
    logic [dsbq_pkg::ACT_W-1:0]   action_reg;
    logic [dsbq_pkg::ACT_W-1:0]   action_next;
    logic [dsbq_pkg::ADDR_W-1:0]  bp_addr_reg;
    logic [dsbq_pkg::ADDR_W-1:0]  bp_addr_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic [dsbq_pkg::HIT_W-1:0]   hit_idx_reg;
    logic [dsbq_pkg::HIT_W-1:0]   hit_idx_next;
    logic [dsbq_pkg::QC_W-1:0]    qcount_reg;
    logic [dsbq_pkg::QC_W-1:0]    qcount_next;
    logic                         drop_reg;
    logic                         drop_next;

    logic                         accept;
    logic                         push_ok;
    logic                         push_high;
    logic                         push_low;
    logic                         range_wr;
    logic                         scan_start;
    logic [dsbq_pkg::CNT_W-1:0]   ring_count;
    logic [dsbq_pkg::ADDR_W-1:0]  ring_rd_data;
    dsbq_pkg::ring_cmd_t          ring_cmd;
    dsbq_pkg::scan_res_t          scan_res;

    assign accept    = start && !busy;
    assign push_ok   = (mode_reg == '0);
    assign push_high = in_addr_reg >= dsbq_pkg::HIGH_ADDR;
    assign push_low  = in_addr_reg < dsbq_pkg::SHUTDOWN_BASE;
    assign range_wr  = write_enable && (reg_index >= dsbq_pkg::CFG_RANGE_A)
                       && (reg_index <= dsbq_pkg::CFG_RANGE_D);

    dsbq_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .wdata   (in_addr_reg),
        .count   (ring_count),
        .rd_data (ring_rd_data)
    );

    dsbq_range_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (range_wr),
        .wr_sel     (reg_index - dsbq_pkg::CFG_RANGE_A),
        .wr_data    (write_data),
        .scan_start (scan_start),
        .token      (token_reg),
        .res        (scan_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsbq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dsbq_pkg::ST_DECODE;
                end
            end
            dsbq_pkg::ST_DECODE:
            begin
                if (opcode_reg == dsbq_pkg::OP_TOKEN)
                begin
                    state_next = dsbq_pkg::ST_SCAN;
                end
                else if (push_ok && !push_high && push_low)
                begin
                    state_next = dsbq_pkg::ST_RETIRE;
                end
                else
                begin
                    state_next = dsbq_pkg::ST_REPORT;
                end
            end
            dsbq_pkg::ST_SCAN:
            begin
                if (scan_res.valid)
                begin
                    if (scan_res.match && !mode_reg[dsbq_pkg::MODE_HOLD_BIT])
                    begin
                        state_next = dsbq_pkg::ST_RETIRE;
                    end
                    else
                    begin
                        state_next = dsbq_pkg::ST_REPORT;
                    end
                end
            end
            dsbq_pkg::ST_RETIRE:
            begin
                // Two or more entries left after the pop need the next address.
                if (ring_count >= dsbq_pkg::CNT_W'(3))
                begin
                    state_next = dsbq_pkg::ST_READ;
                end
                else
                begin
                    state_next = dsbq_pkg::ST_REPORT;
                end
            end
            dsbq_pkg::ST_READ:
            begin
                state_next = dsbq_pkg::ST_REPORT;
            end
            dsbq_pkg::ST_REPORT:
            begin
                state_next = dsbq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dsbq_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy          = (state_reg != dsbq_pkg::ST_IDLE);
        ring_cmd      = '0;
        scan_start    = 1'b0;
        done_next     = 1'b0;
        case (state_reg)
            dsbq_pkg::ST_DECODE:
            begin
                scan_start    = (opcode_reg == dsbq_pkg::OP_TOKEN);
                ring_cmd.push = (opcode_reg == dsbq_pkg::OP_PUSH) && push_ok && push_high
                                && (ring_count < dsbq_pkg::CNT_W'(dsbq_pkg::DEPTH));
            end
            dsbq_pkg::ST_RETIRE:
            begin
                ring_cmd.pop = (ring_count != '0);
            end
            dsbq_pkg::ST_REPORT:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                ring_cmd = '0;
            end
        endcase
    end

    // Item and result registers.
    always_comb
    begin
        mode_next    = mode_reg;
        opcode_next  = opcode_reg;
        in_addr_next = in_addr_reg;
        token_next   = token_reg;
        action_next  = action_reg;
        bp_addr_next = bp_addr_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        qcount_next  = qcount_reg;
        drop_next    = drop_reg;

        if (write_enable && reg_index == dsbq_pkg::CFG_MODE)
        begin
            mode_next = write_data[dsbq_pkg::MODE_W-1:0];
        end

        case (state_reg)
            dsbq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    opcode_next  = opcode;
                    in_addr_next = fifo_address;
                    token_next   = token;
                    action_next  = dsbq_pkg::ACT_NONE;
                    bp_addr_next = '0;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    drop_next    = 1'b0;
                end
            end
            dsbq_pkg::ST_DECODE:
            begin
                if (opcode_reg == dsbq_pkg::OP_PUSH && push_ok && push_high)
                begin
                    if (ring_count >= dsbq_pkg::CNT_W'(dsbq_pkg::DEPTH))
                    begin
                        drop_next = 1'b1;
                    end
                    else if (ring_count == dsbq_pkg::CNT_W'(1))
                    begin
                        // The second entry arms the breakpoint at the new address.
                        action_next  = dsbq_pkg::ACT_ENABLE;
                        bp_addr_next = in_addr_reg;
                    end
                end
            end
            dsbq_pkg::ST_SCAN:
            begin
                if (scan_res.valid)
                begin
                    hit_next     = scan_res.hit;
                    hit_idx_next = scan_res.idx;
                end
            end
            dsbq_pkg::ST_RETIRE:
            begin
                if (ring_count == dsbq_pkg::CNT_W'(2))
                begin
                    action_next = dsbq_pkg::ACT_DISABLE;
                end
                else if (ring_count >= dsbq_pkg::CNT_W'(3))
                begin
                    action_next = dsbq_pkg::ACT_ENABLE;
                end
            end
            dsbq_pkg::ST_READ:
            begin
                bp_addr_next = ring_rd_data;
            end
            dsbq_pkg::ST_REPORT:
            begin
                qcount_next = dsbq_pkg::QC_W'(ring_count);
            end
            default:
            begin
                qcount_next = qcount_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbq_pkg::ST_IDLE;
            mode_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg  <= opcode_next;
        in_addr_reg <= in_addr_next;
        token_reg   <= token_next;
        action_reg  <= action_next;
        bp_addr_reg <= bp_addr_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        qcount_reg  <= qcount_next;
        drop_reg    <= drop_next;
    end

    assign done         = done_reg;
    assign bp_action    = action_reg;
    assign bp_address   = bp_addr_reg;
    assign range_hit    = hit_reg;
    assign hit_index    = hit_idx_reg;
    assign queue_count  = qcount_reg;
    assign push_dropped = drop_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == dsbq_pkg::ST_REPORT))
        else $error("result strobe without a report cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (action_reg != dsbq_pkg::ACT_ENABLE) |-> bp_addr_reg == '0)
        else $error("breakpoint address set without an enable action");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && drop_reg |->
            (qcount_reg == dsbq_pkg::QC_W'(dsbq_pkg::DEPTH))
            && (opcode_reg == dsbq_pkg::OP_PUSH) && (action_reg == dsbq_pkg::ACT_NONE))
        else $error("dropped push with a ring that is not full");

endmodule
`default_nettype wire
